>>> rtl/whole_word_keyword_matcher_defines.svh
// Assertion macros for the whole-word keyword matcher.
`ifndef WHOLE_WORD_KEYWORD_MATCHER_DEFINES_SVH
`define WHOLE_WORD_KEYWORD_MATCHER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define WWKM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define WWKM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/wwkm_pkg.sv
// Types, constants and helper functions shared by the keyword matcher.
package wwkm_pkg;

    localparam int MAX_KEY_LEN = 16;
    localparam int OFFSET_BITS = 16;
    localparam int WIN_DEPTH   = MAX_KEY_LEN + 1;
    localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
    localparam int FILL_W      = $clog2(WIN_DEPTH + 2);
    localparam int LEN_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int START_W     = 16;
    // start offset arithmetic: counter plus room for the keyword length
    localparam int CALC_W      = OFFSET_BITS + LEN_W;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW  = 2'd0,
        CFG_KEY_HIGH = 2'd1,
        CFG_KEY_LEN  = 2'd2
    } t_cfg_reg;

    typedef logic [WIN_DEPTH-1:0][7:0]   t_window;
    typedef logic [MAX_KEY_LEN-1:0][7:0] t_key;
    typedef logic [OFFSET_BITS-1:0]      t_offset;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_line;
    } t_in;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] match_start;
        logic               offset_overflow;
    } t_out;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    // Clamp an offset to the 16-bit result field.
    function automatic logic [START_W-1:0] cap_start(input t_offset off);
        logic [OFFSET_BITS+START_W-1:0] ext;
        ext = (OFFSET_BITS + START_W)'(off);
        if (ext > (OFFSET_BITS + START_W)'({START_W{1'b1}})) begin
            return '1;
        end
        return START_W'(ext);
    endfunction

endpackage

>>> rtl/wwkm_cand.sv
// Whole-word candidate check: keyword ending at window entry 0, with left boundary test.
module wwkm_cand (
    input  wwkm_pkg::t_window                 i_win,
    input  logic [wwkm_pkg::FILL_W-1:0]       i_fill,
    input  wwkm_pkg::t_key                    i_key,
    input  logic [wwkm_pkg::LEN_W-1:0]        i_len,
    output logic                              o_hit
);

    logic                             len_ok;
    logic                             eq;
    logic                             left_ok;
    logic [wwkm_pkg::WIN_IDX_W-1:0]   left_idx;
    logic [wwkm_pkg::LEN_W-1:0]       pos;

    always_comb begin
        len_ok = (i_len >= wwkm_pkg::LEN_W'(1)) &&
                 (i_len <= wwkm_pkg::LEN_W'(wwkm_pkg::MAX_KEY_LEN));
        // key byte j sits len-1-j entries back from the newest byte
        eq  = 1'b1;
        pos = '0;
        for (int j = 0; j < wwkm_pkg::MAX_KEY_LEN; j++) begin
            pos = i_len - wwkm_pkg::LEN_W'(1) - wwkm_pkg::LEN_W'(j);
            if (len_ok && (wwkm_pkg::LEN_W'(j) < i_len)) begin
                if (i_key[j] != i_win[pos[wwkm_pkg::WIN_IDX_W-1:0]]) begin
                    eq = 1'b0;
                end
            end
        end
        left_idx = len_ok ? wwkm_pkg::WIN_IDX_W'(i_len) : '0;
        left_ok  = (i_fill == wwkm_pkg::FILL_W'(i_len)) ||
                   !wwkm_pkg::is_alnum(i_win[left_idx]);
        o_hit    = len_ok && (i_fill >= wwkm_pkg::FILL_W'(i_len)) && eq && left_ok;
    end

endmodule

>>> rtl/whole_word_keyword_matcher.sv
// Whole-word keyword matcher: takes one line byte per cycle and reports the
// first isolated occurrence of the configured keyword on the line's last byte.
// It sustains one byte per cycle with no gaps: a byte is captured in an input
// register, and a single pass of compare logic over the 17-byte window then
// updates the line state; on the last byte the result lands in an output
// register behind the input register. Only a stalled result with a further
// last byte behind it holds the input side back.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
`include "whole_word_keyword_matcher_defines.svh"

module whole_word_keyword_matcher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  wwkm_pkg::t_in                       i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output wwkm_pkg::t_out                      o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wwkm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wwkm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // configuration
    logic [wwkm_pkg::CFG_DATA_W-1:0] r_key_lo;
    logic [wwkm_pkg::CFG_DATA_W-1:0] r_key_hi;
    logic [wwkm_pkg::LEN_W-1:0]      r_key_len;

    // input stage
    logic                            r_in_valid;
    wwkm_pkg::t_in                   r_in;

    // line state
    wwkm_pkg::t_window               r_win;
    logic [wwkm_pkg::FILL_W-1:0]     r_fill;
    wwkm_pkg::t_offset               r_bytes;
    logic                            r_match_seen;
    wwkm_pkg::t_offset               r_match_off;
    logic                            r_over;

    // output stage
    logic                            r_out_valid;
    wwkm_pkg::t_out                  r_out;

    logic                            advance;
    wwkm_pkg::t_key                  key;
    logic [2*wwkm_pkg::CFG_DATA_W-1:0] key_flat;
    wwkm_pkg::t_window               n_win;
    logic [wwkm_pkg::FILL_W-1:0]     fill_plus;
    logic [wwkm_pkg::FILL_W-1:0]     n_fill;
    wwkm_pkg::t_offset               n_bytes;
    logic                            n_match_seen;
    wwkm_pkg::t_offset               n_match_off;
    logic                            n_over;
    logic                            hit_prev;
    logic                            hit_last;
    logic                            cand_prev;
    logic                            cand_last;
    logic [wwkm_pkg::CALC_W-1:0]     diff_prev;
    logic [wwkm_pkg::CALC_W-1:0]     diff_last;
    wwkm_pkg::t_offset               off_prev;
    wwkm_pkg::t_offset               off_last;
    wwkm_pkg::t_out                  n_out;

    assign key_flat = {r_key_hi, r_key_lo};
    assign key      = key_flat[wwkm_pkg::MAX_KEY_LEN*8-1:0];

    assign advance     = r_in_valid && (!r_in.end_of_line || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // window after shifting in the current byte; also the window for a
    // candidate that ends on the current byte
    always_comb begin
        n_win[0] = r_in.text_byte;
        for (int k = 1; k < wwkm_pkg::WIN_DEPTH; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    assign fill_plus = r_fill + wwkm_pkg::FILL_W'(1);

    wwkm_cand u_cand_prev (
        .i_win  (r_win),
        .i_fill (r_fill),
        .i_key  (key),
        .i_len  (r_key_len),
        .o_hit  (hit_prev)
    );

    wwkm_cand u_cand_last (
        .i_win  (n_win),
        .i_fill (fill_plus),
        .i_key  (key),
        .i_len  (r_key_len),
        .o_hit  (hit_last)
    );

    always_comb begin
        cand_prev = hit_prev && !wwkm_pkg::is_alnum(r_in.text_byte);
        cand_last = hit_last && r_in.end_of_line;

        diff_prev = wwkm_pkg::CALC_W'(r_bytes) - wwkm_pkg::CALC_W'(r_key_len);
        diff_last = wwkm_pkg::CALC_W'(r_bytes) + wwkm_pkg::CALC_W'(1) -
                    wwkm_pkg::CALC_W'(r_key_len);
        off_prev  = r_over ? wwkm_pkg::OFFSET_MAX : diff_prev[wwkm_pkg::OFFSET_BITS-1:0];
        off_last  = r_over ? wwkm_pkg::OFFSET_MAX : diff_last[wwkm_pkg::OFFSET_BITS-1:0];

        // the earlier candidate wins, and only the first occurrence is kept
        priority if (r_match_seen || !(cand_prev || cand_last)) begin
            n_match_seen = r_match_seen;
            n_match_off  = r_match_off;
        end else if (cand_prev) begin
            n_match_seen = 1'b1;
            n_match_off  = off_prev;
        end else begin
            n_match_seen = 1'b1;
            n_match_off  = off_last;
        end

        if (r_bytes == wwkm_pkg::OFFSET_MAX) begin
            n_over  = 1'b1;
            n_bytes = r_bytes;
        end else begin
            n_over  = r_over;
            n_bytes = r_bytes + wwkm_pkg::OFFSET_BITS'(1);
        end

        n_fill = (r_fill == wwkm_pkg::FILL_W'(wwkm_pkg::WIN_DEPTH)) ? r_fill : fill_plus;

        n_out.found           = n_match_seen;
        n_out.match_start     = n_match_seen ? wwkm_pkg::cap_start(n_match_off) : '0;
        n_out.offset_overflow = n_over;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo  <= '0;
            r_key_hi  <= '0;
            r_key_len <= wwkm_pkg::LEN_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wwkm_pkg::CFG_KEY_LOW:  r_key_lo  <= i_cfg_data;
                wwkm_pkg::CFG_KEY_HIGH: r_key_hi  <= i_cfg_data;
                wwkm_pkg::CFG_KEY_LEN:  r_key_len <= i_cfg_data[wwkm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // window bytes past the fill count are never looked at, so no reset
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_bytes      <= '0;
            r_match_seen <= 1'b0;
            r_match_off  <= '0;
            r_over       <= 1'b0;
        end else if (advance) begin
            if (r_in.end_of_line) begin
                r_fill       <= '0;
                r_bytes      <= '0;
                r_match_seen <= 1'b0;
                r_match_off  <= '0;
                r_over       <= 1'b0;
            end else begin
                r_fill       <= n_fill;
                r_bytes      <= n_bytes;
                r_match_seen <= n_match_seen;
                r_match_off  <= n_match_off;
                r_over       <= n_over;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.end_of_line) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.end_of_line) begin
            r_out <= n_out;
        end
    end

    `WWKM_ASSERT_NOW(a_no_start_without_match, i_clk, i_rst_n, o_out_valid && !o_out.found, o_out.match_start == '0, "match_start nonzero on a result with no match")
    `WWKM_ASSERT_NEXT(a_line_cleared, i_clk, i_rst_n, advance && r_in.end_of_line, r_fill == '0 && r_bytes == '0 && !r_match_seen && !r_over, "line state not cleared after last byte")
    `WWKM_ASSERT_NOW(a_match_needs_bytes, i_clk, i_rst_n, r_match_seen, r_bytes != '0 && r_fill != '0, "match recorded with no bytes in the line")
    `WWKM_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !r_in_valid, o_in_ready, "input stalled with an empty input stage")

endmodule
